// ----- hw/rtl/xcr_pkg.sv -----
`default_nettype none
package xcr_pkg;

    // Fixed transfer geometry
    localparam int BLOCK_BYTES = 128;
    localparam int MEM_BYTES   = 524288;
    localparam int IDX_W       = $clog2(BLOCK_BYTES);
    localparam int ACC_W       = 21;
    localparam int LEN_W       = 20;
    localparam int OFF_W       = 19;

    // Configuration register indexes
    localparam logic [1:0] REG_MAX_SIZE        = 2'd0;
    localparam logic [1:0] REG_PROMPT_INTERVAL = 2'd1;
    localparam logic [1:0] REG_ERROR_LIMIT     = 2'd2;

    localparam logic [19:0] MAX_SIZE_RST        = 20'd524288;
    localparam logic [31:0] PROMPT_INTERVAL_RST = 32'd50000000;
    localparam logic [2:0]  ERROR_LIMIT_RST     = 3'd3;

    // Control characters
    localparam logic [7:0] CH_SOH    = 8'h01;
    localparam logic [7:0] CH_EOT    = 8'h04;
    localparam logic [7:0] CH_ACK    = 8'h06;
    localparam logic [7:0] CH_NAK    = 8'h15;
    localparam logic [7:0] CH_CAN    = 8'h18;
    localparam logic [7:0] CH_PROMPT = 8'h43;
    localparam logic [7:0] BYTE_ONES = 8'hFF;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Input item kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_TX  = 2'd0;
    localparam logic [1:0] KIND_WR  = 2'd1;
    localparam logic [1:0] KIND_FIN = 2'd2;

    // Finish status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_ERRORS    = 2'd2;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // One command describes all results caused by one input item:
    //   write        : one memory write
    //   tx only      : one transmit byte
    //   tx + fin     : transmit byte, then finish
    //   tx + abort   : transmit byte, CAN, CAN, then finish
    typedef struct packed {
        logic             is_write;
        logic [OFF_W-1:0] offset;
        logic [7:0]       data;
        logic [7:0]       tx;
        logic             fin;
        logic             abort;
        logic [1:0]       status;
        logic [LEN_W-1:0] length;
    } cmd_t;

    // CRC-16 (poly 0x1021, MSB first) over one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Clamp the accepted count to the reported length width
    function automatic logic [LEN_W-1:0] sat_len(input logic [ACC_W-1:0] acc);
        logic [LEN_W-1:0] r;
        r = acc[ACC_W-1] ? {LEN_W{1'b1}} : acc[LEN_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/xmodem_crc_receiver_unit.sv -----
`default_nettype none
// XMODEM-CRC receiver. Each input transfer is one received serial byte or one
// tick (s_tuser). The receiver prompts with 'C' while waiting for the first
// byte, parses 128-byte blocks with CRC-16 checks, and emits results one per
// output transfer: bytes to transmit (ACK, NAK, CAN, 'C'), memory writes of
// data bytes as they arrive, and a finish record with status and length.
// An input item is taken every cycle while the four-entry command queue has
// room; its classification is combinational and its state update registered.
// The output side drains one result per cycle while m_tready is high, and an
// item has zero to four results. Configuration writes are registered and
// belong between transfers.
module xmodem_crc_receiver_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]  s_tuser,   // [0] op
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [7:0] tx_byte, [26:8] wr_offset,
                                        // [34:27] wr_data, [36:35] status,
                                        // [56:37] length, [63:57] zero
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast,   // last
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    xcr_pkg::cmd_t  push_cmd;
    xcr_pkg::cmd_t  head;
    logic           push;
    logic           pop;
    logic           empty;
    logic           full;

    assign s_tready = !full;

    xcr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_tvalid && s_tready),
        .item_op    (s_tuser[0]),
        .item_byte  (s_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .cmd        (push_cmd)
    );

    xcr_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    xcr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/xcr_front.sv -----
`default_nettype none
module xcr_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               item_valid,
    input  wire logic               item_op,
    input  wire logic [7:0]         item_byte,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_wdata,
    output logic                    push,
    output xcr_pkg::cmd_t           cmd
);

    typedef enum logic [2:0] {
        PH_WAIT, PH_HEADER, PH_CAN2, PH_NUM, PH_NUMINV, PH_DATA, PH_CRCH, PH_CRCL
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [xcr_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [7:0]                    hdr_reg, hdr_next;
    logic [15:0]                   crc_reg, crc_next;
    logic [7:0]                    crch_reg, crch_next;
    logic [7:0]                    last_blk_reg, last_blk_next;
    logic [xcr_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [2:0]                    err_reg, err_next;
    logic [31:0]                   tick_reg, tick_next;

    logic [19:0]                   max_size_reg;
    logic [31:0]                   interval_reg;
    logic [2:0]                    err_limit_reg;

    logic                          blk_err;
    logic                          clear;
    logic [31:0]                   tick_inc;
    logic [xcr_pkg::ACC_W-1:0]     wr_off;
    logic [xcr_pkg::ACC_W-1:0]     acc_add;

    assign tick_inc = tick_reg + 32'd1;
    assign wr_off   = acc_reg + xcr_pkg::ACC_W'(idx_reg);
    assign acc_add  = acc_reg + xcr_pkg::ACC_W'(xcr_pkg::BLOCK_BYTES);

    // Classify the item, advance the protocol state and build its command
    always_comb begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        hdr_next      = hdr_reg;
        crc_next      = crc_reg;
        crch_next     = crch_reg;
        last_blk_next = last_blk_reg;
        acc_next      = acc_reg;
        err_next      = err_reg;
        tick_next     = tick_reg;
        push          = 1'b0;
        cmd           = '0;
        blk_err       = 1'b0;
        clear         = 1'b0;

        if (item_valid) begin
            if (item_op == xcr_pkg::OP_TICK) begin
                if (phase_reg == PH_WAIT) begin
                    if (tick_inc > interval_reg) begin
                        push      = 1'b1;
                        cmd.tx    = xcr_pkg::CH_PROMPT;
                        tick_next = '0;
                    end else begin
                        tick_next = tick_inc;
                    end
                end
            end else begin
                unique case (phase_reg)
                    PH_CAN2: begin
                        push    = 1'b1;
                        cmd.tx  = (item_byte == xcr_pkg::CH_CAN) ? xcr_pkg::CH_ACK
                                                                 : xcr_pkg::CH_NAK;
                        blk_err = 1'b1;
                    end
                    PH_NUM: begin
                        hdr_next   = item_byte;
                        phase_next = PH_NUMINV;
                    end
                    PH_NUMINV: begin
                        if (8'(hdr_reg + item_byte) != xcr_pkg::BYTE_ONES) begin
                            push    = 1'b1;
                            cmd.tx  = xcr_pkg::CH_NAK;
                            blk_err = 1'b1;
                        end else begin
                            crc_next   = '0;
                            idx_next   = '0;
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        // drop writes past the size limit or the memory
                        if (wr_off < xcr_pkg::ACC_W'(max_size_reg) &&
                            wr_off < xcr_pkg::ACC_W'(xcr_pkg::MEM_BYTES)) begin
                            push         = 1'b1;
                            cmd.is_write = 1'b1;
                            cmd.offset   = wr_off[xcr_pkg::OFF_W-1:0];
                            cmd.data     = item_byte;
                        end
                        crc_next = xcr_pkg::crc16_byte(crc_reg, item_byte);
                        if (idx_reg == xcr_pkg::IDX_W'(xcr_pkg::BLOCK_BYTES - 1)) begin
                            idx_next   = '0;
                            phase_next = PH_CRCH;
                        end else begin
                            idx_next = idx_reg + xcr_pkg::IDX_W'(1);
                        end
                    end
                    PH_CRCH: begin
                        crch_next  = item_byte;
                        phase_next = PH_CRCL;
                    end
                    PH_CRCL: begin
                        push = 1'b1;
                        if ({crch_reg, item_byte} != crc_reg ||
                            hdr_reg != 8'(last_blk_reg + 8'd1)) begin
                            cmd.tx  = xcr_pkg::CH_NAK;
                            blk_err = 1'b1;
                        end else begin
                            cmd.tx        = xcr_pkg::CH_ACK;
                            last_blk_next = hdr_reg;
                            acc_next      = acc_add;
                            err_next      = '0;
                            phase_next    = PH_HEADER;
                            if (acc_add > xcr_pkg::ACC_W'(max_size_reg)) begin
                                cmd.abort  = 1'b1;
                                cmd.status = xcr_pkg::ST_TOO_LARGE;
                                cmd.length = xcr_pkg::sat_len(acc_add);
                                clear      = 1'b1;
                            end
                        end
                    end
                    PH_WAIT, PH_HEADER: begin
                        if (item_byte == xcr_pkg::CH_EOT) begin
                            push       = 1'b1;
                            cmd.tx     = xcr_pkg::CH_ACK;
                            cmd.fin    = 1'b1;
                            cmd.status = xcr_pkg::ST_OK;
                            cmd.length = xcr_pkg::sat_len(acc_reg);
                            clear      = 1'b1;
                        end else if (item_byte == xcr_pkg::CH_CAN) begin
                            phase_next = PH_CAN2;
                        end else if (item_byte == xcr_pkg::CH_SOH) begin
                            phase_next = PH_NUM;
                        end else begin
                            push    = 1'b1;
                            cmd.tx  = xcr_pkg::CH_NAK;
                            blk_err = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = PH_WAIT;
                    end
                endcase
            end

            // Block error: retry or give up
            if (blk_err) begin
                if (err_reg >= err_limit_reg) begin
                    cmd.abort  = 1'b1;
                    cmd.status = xcr_pkg::ST_ERRORS;
                    cmd.length = xcr_pkg::sat_len(acc_reg);
                    clear      = 1'b1;
                end else begin
                    err_next   = err_reg + 3'd1;
                    phase_next = PH_HEADER;
                end
            end

            // Return to the start of a fresh transfer
            if (clear) begin
                phase_next    = PH_WAIT;
                idx_next      = '0;
                hdr_next      = '0;
                crc_next      = '0;
                crch_next     = '0;
                last_blk_next = '0;
                acc_next      = '0;
                err_next      = '0;
                tick_next     = '0;
            end
        end
    end

    // Hold protocol state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_WAIT;
            idx_reg       <= '0;
            hdr_reg       <= '0;
            crc_reg       <= '0;
            crch_reg      <= '0;
            last_blk_reg  <= '0;
            acc_reg       <= '0;
            err_reg       <= '0;
            tick_reg      <= '0;
            max_size_reg  <= xcr_pkg::MAX_SIZE_RST;
            interval_reg  <= xcr_pkg::PROMPT_INTERVAL_RST;
            err_limit_reg <= xcr_pkg::ERROR_LIMIT_RST;
        end else begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            hdr_reg      <= hdr_next;
            crc_reg      <= crc_next;
            crch_reg     <= crch_next;
            last_blk_reg <= last_blk_next;
            acc_reg      <= acc_next;
            err_reg      <= err_next;
            tick_reg     <= tick_next;
            if (cfg_we) begin
                case (cfg_index)
                    xcr_pkg::REG_MAX_SIZE:        max_size_reg  <= cfg_wdata[19:0];
                    xcr_pkg::REG_PROMPT_INTERVAL: interval_reg  <= cfg_wdata;
                    xcr_pkg::REG_ERROR_LIMIT:     err_limit_reg <= cfg_wdata[2:0];
                    default: ;
                endcase
            end
        end
    end

    a_push_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> item_valid)
        else $error("command pushed without an accepted item");

    a_data_idx_zero_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_DATA) |-> (idx_reg == '0))
        else $error("data index nonzero outside data phase");

    a_tick_held_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_WAIT && phase_next != PH_WAIT) |-> (tick_next == tick_reg))
        else $error("tick count changed after first byte");

endmodule
`default_nettype wire

// ----- hw/rtl/xcr_cmd_fifo.sv -----
`default_nettype none
module xcr_cmd_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire xcr_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output xcr_pkg::cmd_t      head,
    output logic               empty,
    output logic               full
);

    xcr_pkg::cmd_t                   mem [xcr_pkg::CMDQ_DEPTH];
    logic [xcr_pkg::CMDQ_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [xcr_pkg::CMDQ_CNT_W-1:0]  count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == xcr_pkg::CMDQ_CNT_W'(xcr_pkg::CMDQ_DEPTH));
    assign head  = mem[rd_ptr_reg];

    // Store commands
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + xcr_pkg::CMDQ_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + xcr_pkg::CMDQ_PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + xcr_pkg::CMDQ_CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - xcr_pkg::CMDQ_CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full command queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("pop from empty command queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= xcr_pkg::CMDQ_CNT_W'(xcr_pkg::CMDQ_DEPTH))
        else $error("command queue count out of range");

endmodule
`default_nettype wire

// ----- hw/rtl/xcr_back.sv -----
`default_nettype none
module xcr_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire xcr_pkg::cmd_t head,
    input  wire logic          empty,
    output logic               pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [63:0]        m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    xcr_pkg::cmd_t  cur_reg, cur_next;
    logic           cur_valid_reg, cur_valid_next;
    logic [1:0]     step_reg, step_next;

    logic           xfer;
    logic           last_res;
    logic           load;
    logic [1:0]     kind;
    logic [7:0]     tx;
    logic [1:0]     status;
    logic [19:0]    length;

    assign m_tvalid = cur_valid_reg;
    assign xfer     = m_tvalid && m_tready;

    // Pick the result for the current step of the command
    always_comb begin
        kind     = xcr_pkg::KIND_TX;
        tx       = '0;
        status   = '0;
        length   = '0;
        last_res = 1'b0;
        if (cur_reg.is_write) begin
            kind     = xcr_pkg::KIND_WR;
            last_res = 1'b1;
        end else if (cur_reg.abort) begin
            case (step_reg) inside
                2'd0: tx = cur_reg.tx;
                2'd1, 2'd2: tx = xcr_pkg::CH_CAN;
                default: begin
                    kind     = xcr_pkg::KIND_FIN;
                    status   = cur_reg.status;
                    length   = cur_reg.length;
                    last_res = 1'b1;
                end
            endcase
        end else if (cur_reg.fin) begin
            if (step_reg == 2'd0) begin
                tx = cur_reg.tx;
            end else begin
                kind     = xcr_pkg::KIND_FIN;
                status   = cur_reg.status;
                length   = cur_reg.length;
                last_res = 1'b1;
            end
        end else begin
            tx       = cur_reg.tx;
            last_res = 1'b1;
        end
    end

    assign m_tuser = kind;
    assign m_tlast = last_res;
    assign m_tdata = {7'd0, length, status,
                      cur_reg.is_write ? cur_reg.data : 8'd0,
                      cur_reg.is_write ? cur_reg.offset : {xcr_pkg::OFF_W{1'b0}},
                      tx};

    // Take the next command once the current one is fully sent
    assign load = !cur_valid_reg || (xfer && last_res);
    assign pop  = load && !empty;

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        if (load) begin
            cur_valid_next = !empty;
            step_next      = '0;
            if (!empty) begin
                cur_next = head;
            end
        end else if (xfer) begin
            step_next = step_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
        end
        cur_reg <= cur_next;
    end

    a_single_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_valid_reg && !cur_reg.abort && !cur_reg.fin) |-> (step_reg == 2'd0))
        else $error("single-result command advanced past first step");

    a_fin_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_valid_reg && cur_reg.fin && !cur_reg.abort) |-> (step_reg <= 2'd1))
        else $error("finish command advanced too far");

    a_step_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !cur_valid_reg |-> (step_reg == 2'd0))
        else $error("step counter nonzero while idle");

endmodule
`default_nettype wire
